// ===== rtl/hrs_pkg.sv =====
`timescale 1ns / 1ps
// hrs_pkg: types, codes and method tables for the HTTP request splitter.
// No dependencies; imported by every module of the block.
package hrs_pkg;

   localparam int MaxRequestBytes = 1024;
   localparam int CountWidth      = $clog2(MaxRequestBytes);
   localparam int NumMethods      = 6;
   localparam int MethSlots       = 8;

   localparam logic [7:0] ChrCr    = 8'd13;
   localparam logic [7:0] ChrLf    = 8'd10;
   localparam logic [7:0] ChrSpace = 8'd32;
   localparam logic [7:0] ChrNul   = 8'd0;

   // Method names, upper case, zero padded.
   localparam logic [7:0] MethText [NumMethods][MethSlots] = '{
      '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // GET
      '{8'h48, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00},  // HEAD
      '{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // PUT
      '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},  // POST
      '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00},  // DELETE
      '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54, 8'h00}   // CONNECT
   };
   localparam logic [2:0] MethLen [NumMethods] = '{3'd3, 3'd4, 3'd3, 3'd4, 3'd6, 3'd7};

   typedef enum logic [2:0] {
      ClsMethod  = 3'd0,
      ClsSpace   = 3'd1,
      ClsUrl     = 3'd2,
      ClsRest    = 3'd3,
      ClsCrLf    = 3'd4,
      ClsHeader  = 3'd5,
      ClsBody    = 3'd6,
      ClsIgnored = 3'd7
   } class_type;

   typedef enum logic [1:0] {
      ErrNone     = 2'd0,
      ErrNoSpace1 = 2'd1,
      ErrNoSpace2 = 2'd2,
      ErrSpare    = 2'd3
   } error_type;

   localparam logic [2:0] MethUnknown = 3'd0;

   typedef enum logic [5:0] {
      PhMethod = 6'b000001,
      PhUrl    = 6'b000010,
      PhRest   = 6'b000100,
      PhHead   = 6'b001000,
      PhBody   = 6'b010000,
      PhIgnore = 6'b100000
   } phase_type;

   // Step controls from the classifier to the method matcher.
   typedef struct packed {
      logic step;     // an item is processed this cycle
      logic restart;  // request ended: back to reset
      logic compare;  // byte is part of the method token
      logic kill;     // lone CR inside the method
      logic advance;  // bump the token position
   } match_ctl_type;

   function automatic logic [7:0] to_upper(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'd97 && b <= 8'd122) r = b - 8'd32;
      return r;
   endfunction

endpackage

// ===== rtl/hrs_req_if.sv =====
`timescale 1ns / 1ps
// hrs_req_if: request byte channel (valid/ready plus one byte and last flag).
// Standalone; no package dependency.
interface hrs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_in;

   modport source (output valid, output byte_in, output last_in, input ready);
   modport sink   (input valid, input byte_in, input last_in, output ready);
endinterface

// ===== rtl/hrs_rsp_if.sv =====
`timescale 1ns / 1ps
// hrs_rsp_if: classification result channel (valid/ready plus result fields).
// Standalone; no package dependency.
interface hrs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] byte_class;
   logic [2:0] method_code;
   logic       method_valid;
   logic [1:0] error_code;
   logic       done_out;

   modport source (output valid, output byte_class, output method_code,
                   output method_valid, output error_code, output done_out,
                   input ready);
   modport sink   (input valid, input byte_class, input method_code,
                   input method_valid, input error_code, input done_out,
                   output ready);
endinterface

// ===== rtl/hrs_method_match.sv =====
`timescale 1ns / 1ps
// hrs_method_match: case-blind method token matcher (position + candidates).
// Depends on hrs_pkg.
module hrs_method_match (
   input  logic                  clock,
   input  logic                  reset,
   input  hrs_pkg::match_ctl_type ctl,
   input  logic [7:0]            byte_in,
   output logic [2:0]            method_code
);
   import hrs_pkg::*;

   logic [2:0]            pos_ff, pos_in;
   logic [NumMethods-1:0] mask_ff, mask_in;
   logic [7:0]            upper;

   always_comb begin
      upper  = to_upper(byte_in);
      pos_in  = pos_ff;
      mask_in = mask_ff;
      if (ctl.restart) begin
         pos_in  = '0;
         mask_in = '1;
      end else begin
         if (ctl.kill) mask_in = '0;
         if (ctl.compare) begin
            for (int k = 0; k < NumMethods; k++) begin
               if (pos_ff >= MethLen[k] || MethText[k][pos_ff] != upper)
                  mask_in[k] = 1'b0;
            end
         end
         if (ctl.advance && pos_ff != 3'd7) pos_in = pos_ff + 3'd1;
      end
   end

   // Lowest index wins among candidates whose full name was seen.
   always_comb begin
      method_code = MethUnknown;
      for (int k = NumMethods - 1; k >= 0; k--) begin
         if (mask_ff[k] && MethLen[k] == pos_ff) method_code = 3'(k + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         mask_ff <= '1;
      end else if (ctl.step) begin
         pos_ff  <= pos_in;
         mask_ff <= mask_in;
      end
   end

   a_pos_restart : assert property (@(posedge clock) disable iff (reset)
      ctl.step && ctl.restart |=> pos_ff == 3'd0 && mask_ff == '1)
      else $error("matcher did not restart");
   a_pos_hold : assert property (@(posedge clock) disable iff (reset)
      !ctl.step |=> $stable(pos_ff) && $stable(mask_ff))
      else $error("matcher moved without a step");
   a_pos_mono : assert property (@(posedge clock) disable iff (reset)
      ctl.step && !ctl.restart |=> pos_ff >= $past(pos_ff))
      else $error("token position went backward");

endmodule

// ===== rtl/http_request_splitter_top.sv =====
`timescale 1ns / 1ps
// http_request_splitter_top: labels each byte of an HTTP request stream.
// Depends on hrs_pkg, hrs_req_if, hrs_rsp_if, hrs_method_match.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+---------------------------------------
//   req_chan | in  | valid/ready         | byte_in[7:0], last_in
//   rsp_chan | out | valid/ready         | byte_class, method_code, method_valid,
//            |     |                     | error_code, done_out
//
// One item per clock sustained while rsp_chan is ready; each item passes the
// input register, then the classifier between it and the result register.
// The request state (phase, method matcher, CR tracking, byte count) updates
// as the held item moves into the result register.
// A stalled rsp_chan holds the result; the input register still takes one
// more item, then req_chan.ready drops until the result drains.
// reset is synchronous, active high, and restores the state of a new request.
module http_request_splitter_top (
   input logic    clock,
   input logic    reset,
   hrs_req_if.sink   req_chan,
   hrs_rsp_if.source rsp_chan
);
   import hrs_pkg::*;

   // input register
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // result register
   logic       rsp_valid_ff;
   class_type  rsp_class_ff;
   logic [2:0] rsp_code_ff;
   logic       rsp_mvalid_ff;
   logic [1:0] rsp_err_ff;
   logic       rsp_done_ff;

   // request state
   phase_type             phase_ff, phase_in;
   logic [2:0]            found_ff, found_in;
   logic                  prev_cr_ff, prev_cr_in;
   logic                  empty_ff, empty_in;
   error_type             err_ff, err_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic          advance;
   logic          is_cr, is_lf, is_sp, is_nul, lf_end, req_end;
   logic          empty_v;
   class_type     cls;
   phase_type     phase_nx;
   error_type     err_nx;
   logic [2:0]    found_nx;
   logic          empty_nx;
   logic          mvalid;
   logic [2:0]    picked;
   match_ctl_type mctl;

   // handshake: the input register moves whenever the result slot frees up
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;

   hrs_method_match u_match (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mctl),
      .byte_in     (s1_byte_ff),
      .method_code (picked)
   );

   always_comb begin
      is_cr   = (s1_byte_ff == ChrCr);
      is_lf   = (s1_byte_ff == ChrLf);
      is_sp   = (s1_byte_ff == ChrSpace);
      is_nul  = (s1_byte_ff == ChrNul);
      lf_end  = is_lf && prev_cr_ff;
      req_end = s1_last_ff || is_nul ||
                (count_ff == CountWidth'(MaxRequestBytes - 1));

      phase_nx = phase_ff;
      err_nx   = err_ff;
      found_nx = found_ff;
      empty_nx = empty_ff;
      cls      = ClsIgnored;
      empty_v  = empty_ff;

      mctl.step    = advance;
      mctl.restart = req_end;
      mctl.compare = 1'b0;
      mctl.kill    = 1'b0;
      mctl.advance = 1'b0;

      if (!is_nul) begin
         case (phase_ff)
            PhMethod: begin
               if (is_sp) begin
                  cls      = ClsSpace;
                  found_nx = picked;
                  phase_nx = PhUrl;
               end else if (is_cr) begin
                  // lone CR spoils the method token
                  cls          = ClsCrLf;
                  mctl.kill    = 1'b1;
                  mctl.advance = 1'b1;
               end else if (lf_end) begin
                  cls      = ClsCrLf;
                  err_nx   = ErrNoSpace1;
                  phase_nx = PhIgnore;
               end else begin
                  cls          = ClsMethod;
                  mctl.compare = 1'b1;
                  mctl.advance = 1'b1;
               end
            end
            PhUrl: begin
               if (is_sp) begin
                  cls      = ClsSpace;
                  phase_nx = PhRest;
               end else if (is_cr) begin
                  cls = ClsCrLf;
               end else if (lf_end) begin
                  cls      = ClsCrLf;
                  err_nx   = ErrNoSpace2;
                  phase_nx = PhIgnore;
               end else begin
                  cls = ClsUrl;
               end
            end
            PhRest: begin
               if (is_cr) begin
                  cls = ClsCrLf;
               end else if (lf_end) begin
                  cls      = ClsCrLf;
                  phase_nx = PhHead;
                  empty_nx = 1'b1;
               end else begin
                  cls = ClsRest;
               end
            end
            PhHead: begin
               // a CR not followed by LF is line content
               if (prev_cr_ff && !is_lf) empty_v = 1'b0;
               empty_nx = empty_v;
               if (is_cr) begin
                  cls = ClsCrLf;
               end else if (lf_end) begin
                  cls = ClsCrLf;
                  if (empty_v) phase_nx = PhBody;
                  else         empty_nx = 1'b1;
               end else begin
                  cls      = ClsHeader;
                  empty_nx = 1'b0;
               end
            end
            PhBody: cls = ClsBody;
            default: cls = ClsIgnored;
         endcase
      end

      if (req_end) begin
         if (phase_nx == PhMethod)   err_nx = ErrNoSpace1;
         else if (phase_nx == PhUrl) err_nx = ErrNoSpace2;
      end

      mvalid = (phase_nx == PhUrl) || (phase_nx == PhRest) ||
               (phase_nx == PhHead) || (phase_nx == PhBody) ||
               (phase_nx == PhIgnore && err_nx == ErrNoSpace2);

      // next request state: a finished request starts over
      if (req_end) begin
         phase_in   = PhMethod;
         found_in   = MethUnknown;
         prev_cr_in = 1'b0;
         empty_in   = 1'b0;
         err_in     = ErrNone;
         count_in   = '0;
      end else begin
         phase_in   = phase_nx;
         found_in   = found_nx;
         prev_cr_in = is_cr;
         empty_in   = empty_nx;
         err_in     = err_nx;
         count_in   = count_ff + CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_byte_ff <= req_chan.byte_in;
         s1_last_ff <= req_chan.last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_class_ff  <= cls;
         rsp_code_ff   <= mvalid ? found_nx : MethUnknown;
         rsp_mvalid_ff <= mvalid;
         rsp_err_ff    <= err_nx;
         rsp_done_ff   <= req_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhMethod;
         found_ff   <= MethUnknown;
         prev_cr_ff <= 1'b0;
         empty_ff   <= 1'b0;
         err_ff     <= ErrNone;
         count_ff   <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         found_ff   <= found_in;
         prev_cr_ff <= prev_cr_in;
         empty_ff   <= empty_in;
         err_ff     <= err_in;
         count_ff   <= count_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.byte_class   = rsp_class_ff;
   assign rsp_chan.method_code  = rsp_code_ff;
   assign rsp_chan.method_valid = rsp_mvalid_ff;
   assign rsp_chan.error_code   = rsp_err_ff;
   assign rsp_chan.done_out     = rsp_done_ff;

   a_err1_no_method : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff == ErrNoSpace1 |-> !rsp_mvalid_ff)
      else $error("method reported with a missing first space");
   a_end_clears : assert property (@(posedge clock) disable iff (reset)
      advance && req_end |=> count_ff == '0 && phase_ff == PhMethod)
      else $error("request state not cleared at end");
   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("held input item changed");
   a_code_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_mvalid_ff |-> rsp_code_ff == MethUnknown)
      else $error("method code shown before method ended");

endmodule
